/* src/interface_face_marker_macros.svh */
// Assertion macros shared by the interface face marker RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef INTERFACE_FACE_MARKER_MACROS_SVH
`define INTERFACE_FACE_MARKER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IFM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("interface_face_marker: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define IFM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("interface_face_marker: next-cycle check failed");

`endif

/* src/ifm_pkg.sv */
// Package for the interface face marker: widths, codes and record types.
// Used by every RTL file of the block; depends on nothing.
package ifm_pkg;

  localparam int MAX_CELLS = 4096;
  localparam int CELL_W    = 12;
  localparam int ADDR_W    = $clog2(MAX_CELLS);
  localparam int FRAC_W    = 16;
  localparam int FACE_W    = 16;
  localparam int POS_W     = 32;
  localparam int NRM_W     = 16;
  localparam int MODE_W    = 2;
  localparam int CFG_W     = 16;

  localparam logic [FRAC_W-1:0] LEVEL_RST = 16'd16384;

  // Restoring divider: one quotient bit per stage, 17 bits for 0..65536.
  localparam int DIV_N   = 17;
  localparam int ANUM_W  = 16;
  localparam int ADIFF_W = 17;
  localparam int REM_W   = ADIFF_W + 1;
  localparam int PROD_W  = POS_W + 1 + DIV_N + 1;
  localparam int ERR_W   = POS_W + 4;
  localparam int MUL2_W  = ERR_W + NRM_W;
  localparam int SIDE_W  = MUL2_W + 2;
  localparam int NSTG    = DIV_N + 3;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  typedef enum logic [0:0] {
    CFG_MARK_MODE = 1'b0,
    CFG_LEVEL     = 1'b1
  } cfg_idx_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_SIDE   = 2'd0,
    MODE_DOUBLE = 2'd1,
    MODE_PAIR   = 2'd2
  } mark_mode_t;

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_FACE = 1'b1
  } op_t;

  typedef struct packed {
    logic [FRAC_W-1:0]           frac;
    logic [2:0][POS_W-1:0]       pos;
  } cell_rec_t;

  // One accepted face on its way from the front to the back.
  typedef struct packed {
    logic [CELL_W-1:0]           own;
    logic [CELL_W-1:0]           nei;
    logic [FACE_W-1:0]           face;
    logic [FRAC_W-1:0]           ov;
    logic [FRAC_W-1:0]           nv;
    logic [MODE_W-1:0]           mode;
    logic [ANUM_W-1:0]           anum;
    logic [ADIFF_W-1:0]          adiff;
    logic [2:0][POS_W-1:0]       oc;
    logic [2:0][POS_W-1:0]       fc;
    logic [2:0][POS_W:0]         d;
    logic [2:0][NRM_W-1:0]       nrm;
  } job_t;

  typedef struct packed {
    logic [CELL_W-1:0]           marked_cell;
    logic [CELL_W-1:0]           paired_cell;
    logic [FACE_W-1:0]           pair_face;
    logic [FRAC_W-1:0]           high_fraction;
    logic [FRAC_W-1:0]           low_fraction;
    logic                        last;
  } res_t;

endpackage

/* src/ifm_in_if.sv */
// Input channel of the interface face marker: valid/ready plus item fields.
// Depends on ifm_pkg for the field widths.
interface ifm_in_if import ifm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic [CELL_W-1:0]        first_cell;
  logic [CELL_W-1:0]        second_cell;
  logic [FACE_W-1:0]        face_number;
  logic [FRAC_W-1:0]        fraction_value;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [POS_W-1:0]  pos_z;
  logic signed [NRM_W-1:0]  normal_x;
  logic signed [NRM_W-1:0]  normal_y;
  logic signed [NRM_W-1:0]  normal_z;

  modport source (output valid, opcode, first_cell, second_cell, face_number,
                  fraction_value, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
                  input ready);
  modport sink   (input valid, opcode, first_cell, second_cell, face_number,
                  fraction_value, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
                  output ready);
endinterface

/* src/ifm_out_if.sv */
// Result channel of the interface face marker: valid/ready plus result fields.
// Depends on ifm_pkg for the field widths.
interface ifm_out_if import ifm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CELL_W-1:0]   marked_cell;
  logic [CELL_W-1:0]   paired_cell;
  logic [FACE_W-1:0]   pair_face;
  logic [FRAC_W-1:0]   high_fraction;
  logic [FRAC_W-1:0]   low_fraction;
  logic                last;

  modport source (output valid, marked_cell, paired_cell, pair_face, high_fraction,
                  low_fraction, last, input ready);
  modport sink   (input valid, marked_cell, paired_cell, pair_face, high_fraction,
                  low_fraction, last, output ready);
endinterface

/* src/ifm_queue.sv */
// Short job queue between the front and back of the interface face marker.
// Depends on ifm_pkg and the assertion macros header.
`include "interface_face_marker_macros.svh"

module ifm_queue import ifm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic push_ready,
  input  logic pop,
  output logic pop_valid,
  output job_t pop_job
);

  job_t                 slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_PTR_W:0]     cnt_r, cnt_nxt;
  logic                 full, empty;

  assign full       = (cnt_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign empty      = (cnt_r == '0);
  assign push_ready = !full;
  assign pop_valid  = !empty;
  assign pop_job    = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  `IFM_ASSERT_NOW(a_q_no_overflow, push, !full)
  `IFM_ASSERT_NOW(a_q_no_underflow, pop, !empty)
  `IFM_ASSERT_NEXT(a_q_push_counts, push && !pop, cnt_r != '0)

endmodule

/* src/ifm_front.sv */
// Front of the interface face marker: takes items, keeps the cell memory,
// classifies faces and queues the ones that pass. Depends on ifm_pkg and ifm_in_if.
module ifm_front import ifm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [MODE_W-1:0]  mark_mode,
  input  logic [FRAC_W-1:0]  level,
  ifm_in_if.sink             in_ch,
  output logic               push,
  output job_t               push_job,
  input  logic               push_ready
);

  localparam logic [CELL_W:0] CELL_LIM = (CELL_W+1)'(MAX_CELLS);

  cell_rec_t cell_mem [MAX_CELLS];
  cell_rec_t own_rec_r, nei_rec_r;

  logic                  a_v_r;
  logic [CELL_W-1:0]     own_r, nei_r;
  logic [FACE_W-1:0]     face_r;
  logic [2:0][POS_W-1:0] fc_r;
  logic [2:0][NRM_W-1:0] nrm_r;

  logic               accept, is_load, load_ok;
  logic               own_ok, nei_ok, mode_ok, ratio_ok, pass, a_go;
  logic signed [17:0] diff, num;
  logic [17:0]        anum_full, adiff_full;

  assign accept  = in_ch.valid && in_ch.ready;
  assign is_load = (op_t'(in_ch.opcode) == OP_LOAD);
  assign load_ok = ({1'b0, in_ch.first_cell} < CELL_LIM);

  // Loads write at accept; faces read both cells, data registered here.
  always_ff @(posedge clk) begin
    if (accept && is_load && load_ok) begin
      cell_mem[ADDR_W'(in_ch.first_cell)] <= {in_ch.fraction_value, in_ch.pos_z,
                                              in_ch.pos_y, in_ch.pos_x};
    end
    if (accept && !is_load) begin
      own_rec_r <= cell_mem[ADDR_W'(in_ch.first_cell)];
      nei_rec_r <= cell_mem[ADDR_W'(in_ch.second_cell)];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_load) begin
      own_r  <= in_ch.first_cell;
      nei_r  <= in_ch.second_cell;
      face_r <= in_ch.face_number;
      fc_r   <= {in_ch.pos_z, in_ch.pos_y, in_ch.pos_x};
      nrm_r  <= {in_ch.normal_z, in_ch.normal_y, in_ch.normal_x};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (accept) begin
      a_v_r <= !is_load;
    end else if (a_go) begin
      a_v_r <= 1'b0;
    end
  end

  // Classification of the face held in the read stage.
  always_comb begin
    own_ok  = ({1'b0, own_r} < CELL_LIM);
    nei_ok  = ({1'b0, nei_r} < CELL_LIM);
    mode_ok = (mark_mode == MODE_SIDE) || (mark_mode == MODE_DOUBLE) ||
              (mark_mode == MODE_PAIR);
    diff = $signed({2'b00, nei_rec_r.frac}) - $signed({2'b00, own_rec_r.frac}) + 18'sd1;
    num  = $signed({2'b00, level}) - $signed({2'b00, own_rec_r.frac});
    if (diff > 0) begin
      ratio_ok = (num >= 0) && (num <= diff);
    end else begin
      ratio_ok = (diff != 0) && (num <= 0) && (num >= diff);
    end
    pass       = own_ok && nei_ok && mode_ok && ratio_ok;
    anum_full  = (num < 0) ? 18'(-num) : 18'(num);
    adiff_full = (diff < 0) ? 18'(-diff) : 18'(diff);
  end

  always_comb begin
    push_job       = '0;
    push_job.own   = own_r;
    push_job.nei   = nei_r;
    push_job.face  = face_r;
    push_job.ov    = own_rec_r.frac;
    push_job.nv    = nei_rec_r.frac;
    push_job.mode  = mark_mode;
    push_job.anum  = anum_full[ANUM_W-1:0];
    push_job.adiff = adiff_full[ADIFF_W-1:0];
    push_job.oc    = own_rec_r.pos;
    push_job.fc    = fc_r;
    push_job.nrm   = nrm_r;
    for (int i = 0; i < 3; i++) begin
      push_job.d[i] = $signed({nei_rec_r.pos[i][POS_W-1], nei_rec_r.pos[i]}) -
                      $signed({own_rec_r.pos[i][POS_W-1], own_rec_r.pos[i]});
    end
  end

  assign push        = a_v_r && pass && push_ready;
  assign a_go        = !pass || push_ready;
  assign in_ch.ready = !a_v_r || a_go;

endmodule

/* src/ifm_back.sv */
// Back of the interface face marker: divider, side test and result emission.
// Depends on ifm_pkg, ifm_out_if and the assertion macros header.
`include "interface_face_marker_macros.svh"

module ifm_back import ifm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_valid,
  input  job_t     q_job,
  output logic     pop,
  ifm_out_if.source out_ch
);

  localparam int S_MUL = DIV_N;
  localparam int S_ERR = DIV_N + 1;
  localparam int S_SQ  = DIV_N + 2;

  job_t                      job_r [NSTG];
  logic [NSTG-1:0]           v_r;
  logic [REM_W-1:0]          rem_r [DIV_N];
  logic [DIV_N-1:0]          quo_r [DIV_N];
  logic [REM_W-1:0]          rem_nxt [DIV_N];
  logic [DIV_N-1:0]          quo_nxt [DIV_N];
  logic signed [PROD_W-1:0]  prod_r [3];
  logic signed [ERR_W-1:0]   err_r [3];
  logic signed [MUL2_W-1:0]  sq_r [3];

  res_t              em_res_r, em_res_nxt, res_out;
  logic [CELL_W-1:0] em_cell1_r, em_cell1_nxt;
  logic              em_two_r, em_two_nxt, em_v_r, sel_r, adv;
  logic signed [SIDE_W-1:0] side;

  // One restoring step per stage; step 0 gives the integer bit.
  always_comb begin
    logic [REM_W-1:0]   rin;
    logic [DIV_N-1:0]   qin;
    logic [ADIFF_W-1:0] dv;
    logic               ge;
    for (int k = 0; k < DIV_N; k++) begin
      if (k == 0) begin
        rin = REM_W'(q_job.anum);
        qin = '0;
        dv  = q_job.adiff;
      end else begin
        rin = {rem_r[k-1][REM_W-2:0], 1'b0};
        qin = quo_r[k-1];
        dv  = job_r[k-1].adiff;
      end
      ge         = (rin >= REM_W'(dv));
      rem_nxt[k] = ge ? (rin - REM_W'(dv)) : rin;
      quo_nxt[k] = {qin[DIV_N-2:0], ge};
    end
  end

  assign adv = !em_v_r || (out_ch.ready && (sel_r || !em_two_r));
  assign pop = adv && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NSTG-2:0], q_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      job_r[0] <= q_job;
      for (int k = 1; k < NSTG; k++) begin
        job_r[k] <= job_r[k-1];
      end
      for (int k = 0; k < DIV_N; k++) begin
        rem_r[k] <= rem_nxt[k];
        quo_r[k] <= quo_nxt[k];
      end
      for (int i = 0; i < 3; i++) begin
        prod_r[i] <= $signed(job_r[S_MUL-1].d[i]) * $signed({1'b0, quo_r[DIV_N-1]});
        err_r[i]  <= ERR_W'($signed(job_r[S_ERR-1].fc[i]) - $signed(job_r[S_ERR-1].oc[i])
                     - (prod_r[i] >>> 16));
        sq_r[i]   <= err_r[i] * $signed(job_r[S_SQ-1].nrm[i]);
      end
    end
  end

  // Result selection for the face leaving the last stage.
  always_comb begin
    side         = SIDE_W'(sq_r[0]) + SIDE_W'(sq_r[1]) + SIDE_W'(sq_r[2]);
    em_res_nxt   = '0;
    em_cell1_nxt = job_r[S_SQ].nei;
    em_two_nxt   = 1'b0;
    case (mark_mode_t'(job_r[S_SQ].mode))
      MODE_SIDE: begin
        em_res_nxt.marked_cell = (side < 0) ? job_r[S_SQ].nei : job_r[S_SQ].own;
        em_res_nxt.last        = (side != 0);
        em_two_nxt             = (side == 0);
      end
      MODE_DOUBLE: begin
        em_res_nxt.marked_cell = job_r[S_SQ].own;
        em_two_nxt             = 1'b1;
      end
      MODE_PAIR: begin
        em_res_nxt.pair_face = job_r[S_SQ].face;
        em_res_nxt.last      = 1'b1;
        if (job_r[S_SQ].ov >= job_r[S_SQ].nv) begin
          em_res_nxt.marked_cell   = job_r[S_SQ].own;
          em_res_nxt.paired_cell   = job_r[S_SQ].nei;
          em_res_nxt.high_fraction = job_r[S_SQ].ov;
          em_res_nxt.low_fraction  = job_r[S_SQ].nv;
        end else begin
          em_res_nxt.marked_cell   = job_r[S_SQ].nei;
          em_res_nxt.paired_cell   = job_r[S_SQ].own;
          em_res_nxt.high_fraction = job_r[S_SQ].nv;
          em_res_nxt.low_fraction  = job_r[S_SQ].ov;
        end
      end
      default: begin
        em_res_nxt.last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_v_r <= 1'b0;
      sel_r  <= 1'b0;
    end else if (adv) begin
      em_v_r <= v_r[S_SQ];
      sel_r  <= 1'b0;
    end else if (out_ch.ready) begin
      sel_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      em_res_r   <= em_res_nxt;
      em_cell1_r <= em_cell1_nxt;
      em_two_r   <= em_two_nxt;
    end
  end

  always_comb begin
    res_out = em_res_r;
    if (sel_r) begin
      res_out             = '0;
      res_out.marked_cell = em_cell1_r;
      res_out.last        = 1'b1;
    end
  end

  assign out_ch.valid         = em_v_r;
  assign out_ch.marked_cell   = res_out.marked_cell;
  assign out_ch.paired_cell   = res_out.paired_cell;
  assign out_ch.pair_face     = res_out.pair_face;
  assign out_ch.high_fraction = res_out.high_fraction;
  assign out_ch.low_fraction  = res_out.low_fraction;
  assign out_ch.last          = res_out.last;

  `IFM_ASSERT_NOW(a_sel_needs_two, sel_r, em_v_r && em_two_r)
  `IFM_ASSERT_NOW(a_first_of_two_not_last, em_v_r && em_two_r && !sel_r, !em_res_r.last)
  `IFM_ASSERT_NEXT(a_second_follows, em_v_r && em_two_r && !sel_r && out_ch.ready,
                   em_v_r && sel_r)

endmodule

/* src/interface_face_marker.sv */
// Top level of the interface face marker: configuration registers and the
// front, queue and back. Depends on ifm_pkg, ifm_in_if, ifm_out_if and the submodules.

// The block marks mesh cells that touch a volume-fraction interface. Load items
// (opcode 0) store a cell's fraction and centre in a 4096-entry cell memory and
// give no result; face items (opcode 1) read the owner and neighbour cells and,
// if the interface level falls between their fractions, give one or two result
// items as chosen by mark_mode. A face must only name cells that were loaded
// since reset; the memory is not cleared. The block takes one item per cycle
// when neither the queue nor the output is backed up: the front registers the
// cell memory read at the accepting edge and classifies the face in the next
// cycle, a four-entry queue decouples it from the back, and the back runs a
// 17-stage one-bit-per-stage divider for the interpolation ratio, then a
// multiply, an error stage and a normal dot-product stage before the output
// register. A face that gives two results holds the output register until both
// have been taken, and the back takes no new face meanwhile; all others stream
// at one per cycle while the receiver is ready. Configuration is written through
// cfg_we/cfg_idx/cfg_data (index 0 mark_mode, index 1 interface_level); the user
// must do so only while the block is idle, which the block itself does not enforce.
module interface_face_marker import ifm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_idx,
  input  logic [CFG_W-1:0] cfg_data,
  ifm_in_if.sink           in_ch,
  ifm_out_if.source        out_ch
);

  logic [MODE_W-1:0] mode_r;
  logic [FRAC_W-1:0] level_r;

  logic q_push, q_push_ready, q_pop, q_valid;
  job_t q_push_job, q_job;

  // Configuration registers; an index with no register is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_SIDE;
      level_r <= LEVEL_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_MARK_MODE: mode_r  <= cfg_data[MODE_W-1:0];
        CFG_LEVEL:     level_r <= cfg_data[FRAC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front: cell memory, face classification.
  ifm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .mark_mode  (mode_r),
    .level      (level_r),
    .in_ch      (in_ch),
    .push       (q_push),
    .push_job   (q_push_job),
    .push_ready (q_push_ready)
  );

  // Queue of faces that passed the ratio test.
  ifm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_push_job),
    .push_ready (q_push_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_job    (q_job)
  );

  // Back: division, side test and result items.
  ifm_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_job   (q_job),
    .pop     (q_pop),
    .out_ch  (out_ch)
  );

endmodule

/* tb/ifm_marking_checker.sv */
// Checker for the interface face marker: watches both channels and the
// configuration port, predicts the marked cells of every face and compares.
// Depends on ifm_pkg, ifm_in_if and ifm_out_if.
module ifm_marking_checker import ifm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_idx,
  input  logic [CFG_W-1:0] cfg_data,
  ifm_in_if                in_ch,
  ifm_out_if               out_ch,
  output int               errors,
  output int               marks_pending,
  output int               marks_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [FRAC_W-1:0]       cell_frac [MAX_CELLS];
  logic signed [POS_W-1:0] cell_pos  [MAX_CELLS][3];
  logic [MODE_W-1:0]       cur_mode;
  logic [FRAC_W-1:0]       cur_level;
  res_t                    marks_due[$];

  assign marks_pending = marks_due.size();

  function automatic res_t mark(logic [CELL_W-1:0] mc, logic [CELL_W-1:0] pc,
                                logic [FACE_W-1:0] pf, logic [FRAC_W-1:0] hf,
                                logic [FRAC_W-1:0] lf, logic lst);
    res_t r;
    r.marked_cell = mc;
    r.paired_cell = pc;
    r.pair_face = pf;
    r.high_fraction = hf;
    r.low_fraction = lf;
    r.last = lst;
    return r;
  endfunction

  // Works out the marks of one face and queues them in output order.
  task automatic predict_face_marks();
    logic [CELL_W-1:0] own, nei;
    longint ov, nv, num, diff, anum, adiff, tq, oc, nc, fc, nrm, p, side;
    own = in_ch.first_cell;
    nei = in_ch.second_cell;
    if (cur_mode > MODE_PAIR) return;
    ov = cell_frac[own];
    nv = cell_frac[nei];
    diff = nv - ov + 1;
    num = longint'(cur_level) - ov;
    if (diff == 0) return;
    if (diff > 0 && (num < 0 || num > diff)) return;
    if (diff < 0 && (num > 0 || num < diff)) return;
    if (cur_mode == MODE_DOUBLE) begin
      marks_due.push_back(mark(own, '0, '0, '0, '0, 1'b0));
      marks_due.push_back(mark(nei, '0, '0, '0, '0, 1'b1));
      return;
    end
    if (cur_mode == MODE_PAIR) begin
      if (ov >= nv)
        marks_due.push_back(mark(own, nei, in_ch.face_number, FRAC_W'(ov), FRAC_W'(nv),
                                 1'b1));
      else
        marks_due.push_back(mark(nei, own, in_ch.face_number, FRAC_W'(nv), FRAC_W'(ov),
                                 1'b1));
      return;
    end
    // Side test: interpolate the interface point along owner->neighbour,
    // then project face centre minus that point onto the normal.
    anum = num < 0 ? -num : num;
    adiff = diff < 0 ? -diff : diff;
    tq = (anum << 16) / adiff;
    side = 0;
    for (int i = 0; i < 3; i++) begin
      oc = cell_pos[own][i];
      nc = cell_pos[nei][i];
      fc = (i == 0) ? longint'(in_ch.pos_x) : (i == 1) ? longint'(in_ch.pos_y)
                                                       : longint'(in_ch.pos_z);
      nrm = (i == 0) ? longint'(in_ch.normal_x) : (i == 1) ? longint'(in_ch.normal_y)
                                                           : longint'(in_ch.normal_z);
      p = oc + (((nc - oc) * tq) >>> 16);
      side += (fc - p) * nrm;
    end
    if (side >= 0) marks_due.push_back(mark(own, '0, '0, '0, '0, side > 0));
    if (side <= 0) marks_due.push_back(mark(nei, '0, '0, '0, '0, 1'b1));
  endtask

  task automatic compare_mark();
    res_t e;
    bit bad;
    marks_seen++;
    if (marks_due.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: unexpected result item, cell %0d", $realtime, out_ch.marked_cell);
      return;
    end
    e = marks_due.pop_front();
    bad = (out_ch.marked_cell !== e.marked_cell) || (out_ch.paired_cell !== e.paired_cell)
       || (out_ch.pair_face !== e.pair_face) || (out_ch.high_fraction !== e.high_fraction)
       || (out_ch.low_fraction !== e.low_fraction) || (out_ch.last !== e.last);
    if (bad) begin
      errors++;
      if (errors <= 10)
        $display({"%0t: mismatch exp cell %0d pair %0d face %0d hi %0d lo %0d last %0b,",
                  " got %0d %0d %0d %0d %0d %0b"},
                 $realtime, e.marked_cell, e.paired_cell, e.pair_face, e.high_fraction,
                 e.low_fraction, e.last, out_ch.marked_cell, out_ch.paired_cell,
                 out_ch.pair_face, out_ch.high_fraction, out_ch.low_fraction, out_ch.last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cur_mode <= MODE_SIDE;
      cur_level <= LEVEL_RST;
      marks_due.delete();
      errors <= 0;
      marks_seen <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_MARK_MODE) cur_mode <= cfg_data[MODE_W-1:0];
        else cur_level <= cfg_data;
      end
      if (out_ch.valid && out_ch.ready) compare_mark();
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.opcode == OP_LOAD) begin
          cell_frac[in_ch.first_cell] = in_ch.fraction_value;
          cell_pos[in_ch.first_cell][0] = in_ch.pos_x;
          cell_pos[in_ch.first_cell][1] = in_ch.pos_y;
          cell_pos[in_ch.first_cell][2] = in_ch.pos_z;
        end else begin
          predict_face_marks();
        end
      end
    end
  end
endmodule

/* tb/interface_face_marker_tb.sv */
// Testbench top for the interface face marker: clock, reset, configuration,
// face and load stimulus, receiver stalls and the verdict.
// Depends on ifm_pkg, ifm_in_if, ifm_out_if, ifm_marking_checker and the block.
module interface_face_marker_tb;
  import ifm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // A mark_mode value with no meaning; faces must give nothing under it.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int POOL_N = 32;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 85;
  localparam int DRAIN_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [0:0]       cfg_idx = CFG_MARK_MODE;
  logic [CFG_W-1:0] cfg_data = '0;
  int               errors, marks_pending, marks_seen;
  idle_t            idling = IDLE_NONE;
  bit               want_hold = 1'b0;
  int               phase_no = 0;
  int               quiet_cycles = 0;
  int               faces_sent = 0, loads_sent = 0;
  logic [FRAC_W-1:0] level_now = LEVEL_RST;
  logic [CELL_W-1:0] cell_pool [POOL_N];

  ifm_in_if  in_ch();
  ifm_out_if out_ch();

  interface_face_marker uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  ifm_marking_checker checker_i (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch), .errors(errors), .marks_pending(marks_pending),
    .marks_seen(marks_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: stalls follow the current idling pattern. Once, while
  // want_hold is up, it refuses everything for a long stretch so the block
  // backs up and throttles its input.
  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (want_hold && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (idling == IDLE_RECEIVER) begin
        out_ch.ready <= ($urandom_range(99) >= 86);
      end else if (idling == IDLE_BOTH) begin
        out_ch.ready <= ($urandom_range(99) >= 9);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // The watchdog counts cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired in phase %0d, %0d results outstanding",
               phase_no, marks_pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic offer(logic op, logic [CELL_W-1:0] c1, logic [CELL_W-1:0] c2,
                       logic [FACE_W-1:0] fn, logic [FRAC_W-1:0] fr,
                       logic [POS_W-1:0] px, logic [POS_W-1:0] py, logic [POS_W-1:0] pz,
                       logic [NRM_W-1:0] nx, logic [NRM_W-1:0] ny, logic [NRM_W-1:0] nz);
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.first_cell <= c1;
    in_ch.second_cell <= c2;
    in_ch.face_number <= fn;
    in_ch.fraction_value <= fr;
    in_ch.pos_x <= px;
    in_ch.pos_y <= py;
    in_ch.pos_z <= pz;
    in_ch.normal_x <= nx;
    in_ch.normal_y <= ny;
    in_ch.normal_z <= nz;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    if (op == OP_LOAD) loads_sent++;
    else faces_sent++;
  endtask

  task automatic sender_gap();
    int pct;
    pct = (idling == IDLE_SENDER) ? 86 : (idling == IDLE_BOTH) ? 9 : 0;
    while ($urandom_range(99) < pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_LEVEL) level_now = val;
  endtask

  // Waits until every expected result has come, then lets the pipeline
  // finish whatever loads or skipped faces are still in flight.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (marks_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Fractions cluster around the interface level so that many faces pass.
  function automatic logic [FRAC_W-1:0] pick_fraction();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'd32768;
      2: return level_now;
      3: return level_now + 16'($urandom_range(4)) - 16'd2;
      4: return 16'($urandom_range(32768));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    case ($urandom_range(3))
      0: return 32'($urandom_range(65536 * 8)) - 32'd262144;
      default: return $urandom;
    endcase
  endfunction

  task automatic load_cell(logic [CELL_W-1:0] c);
    offer(OP_LOAD, c, 12'($urandom), 16'($urandom), pick_fraction(),
          pick_pos(), pick_pos(), pick_pos(), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // Mostly faces between pool cells, some reloads, a little noise with
  // random centres and normals, all on cells that were loaded.
  task automatic random_item();
    int r;
    r = $urandom_range(99);
    if (r < 25) begin
      load_cell(cell_pool[$urandom_range(POOL_N - 1)]);
    end else begin
      offer(OP_FACE, cell_pool[$urandom_range(POOL_N - 1)],
            cell_pool[$urandom_range(POOL_N - 1)], 16'($urandom), 16'($urandom),
            pick_pos(), pick_pos(), pick_pos(), 16'($urandom), 16'($urandom),
            16'($urandom));
    end
  endtask

  task automatic directed_items();
    // Lowest and highest cell indexes with empty, full and above-one fractions.
    offer(OP_LOAD, 12'd0, 12'd0, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0, 16'd0, 16'd0, 16'd0);
    offer(OP_LOAD, 12'd4095, 12'd4095, 16'hFFFF, 16'd32768, 32'h7FFF_FFFF,
          32'h8000_0000, 32'd0, 16'h7FFF, 16'h8000, 16'd0);
    offer(OP_LOAD, 12'd1, 12'd0, 16'd0, 16'd16384, 32'd0, 32'd0, 32'd0, 16'd0, 16'd0, 16'd0);
    offer(OP_LOAD, 12'd2, 12'd0, 16'd0, 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF,
          32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0);
    // Zero normal: side is exactly zero, so both cells are marked.
    offer(OP_FACE, 12'd0, 12'd4095, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0,
          16'd0, 16'd0, 16'd0);
    // Strongly positive and strongly negative sides.
    offer(OP_FACE, 12'd0, 12'd4095, 16'hFFFF, 16'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          32'h7FFF_FFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    offer(OP_FACE, 12'd0, 12'd4095, 16'd7, 16'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          32'h7FFF_FFFF, 16'h8000, 16'h8000, 16'h8000);
    // Falling fraction across the face, so the difference is negative.
    offer(OP_FACE, 12'd4095, 12'd0, 16'd9, 16'd0, 32'h8000_0000, 32'd0, 32'd0,
          16'h8000, 16'd0, 16'd0);
    // Same cell twice: difference of one, level far away, skipped.
    offer(OP_FACE, 12'd0, 12'd0, 16'd3, 16'd0, 32'd0, 32'd0, 32'd0, 16'd1, 16'd1, 16'd1);
    // Owner exactly at the level: ratio zero.
    offer(OP_FACE, 12'd1, 12'd1, 16'd4, 16'd0, 32'd5, 32'd0, 32'd0, 16'h4000, 16'd0, 16'd0);
    // Fraction above one against an empty cell.
    offer(OP_FACE, 12'd2, 12'd0, 16'd5, 16'd0, 32'd0, 32'd0, 32'h1_0000, 16'd0, 16'd0,
          16'h7FFF);
    offer(OP_FACE, 12'd1, 12'd4095, 16'd6, 16'd0, 32'hFFFF_0000, 32'd0, 32'd0,
          16'd0, 16'hFFFF, 16'd0);
  endtask

  initial begin
    logic [MODE_W-1:0] modes  [PHASES];
    logic [FRAC_W-1:0] levels [PHASES];
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_LOAD;
    in_ch.first_cell = '0;
    in_ch.second_cell = '0;
    in_ch.face_number = '0;
    in_ch.fraction_value = '0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.pos_z = '0;
    in_ch.normal_x = '0;
    in_ch.normal_y = '0;
    in_ch.normal_z = '0;
    modes  = '{MODE_SIDE, MODE_DOUBLE, MODE_PAIR, MODE_SIDE, MODE_SIDE, MODE_UNUSED,
               MODE_PAIR, MODE_SIDE, MODE_DOUBLE, MODE_SIDE};
    levels = '{16'd16384, 16'd0, 16'd32768, 16'd0, 16'd32768, 16'd16384,
               16'($urandom_range(32768)), 16'($urandom_range(32768)),
               16'($urandom_range(32768)), 16'd16384};
    // The pool always holds both end cells; the rest are random indexes.
    cell_pool[0] = 12'd0;
    cell_pool[1] = 12'd4095;
    for (int i = 2; i < POOL_N; i++) cell_pool[i] = 12'($urandom);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset values of the registers get the directed faces first.
    directed_items();
    drain();
    foreach (cell_pool[i]) load_cell(cell_pool[i]);

    for (int ph = 0; ph < PHASES; ph++) begin
      phase_no = ph;
      drain();
      write_reg(CFG_MARK_MODE, CFG_W'(modes[ph]));
      write_reg(CFG_LEVEL, levels[ph]);
      idling = idle_t'(ph % 4);
      // Phase four has a steady sender against a receiver that holds off.
      if (ph == 4) want_hold = 1'b1;
      // Reload the pool so fractions follow the new level.
      foreach (cell_pool[i]) begin
        load_cell(cell_pool[i]);
        sender_gap();
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_item();
        sender_gap();
        // Now and then the sender waits for every result before going on.
        if (n == PHASE_ITEMS / 2 && ph % 3 == 0) drain();
      end
    end

    drain();
    $display("Covered %0d loads and %0d faces over %0d register settings and four",
             loads_sent, faces_sent, PHASES);
    $display("idling patterns, with %0d result items checked", marks_seen);
    if (errors == 0 && marks_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, marks_pending);
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

/* files.f */
+incdir+src
src/ifm_pkg.sv
src/ifm_in_if.sv
src/ifm_out_if.sv
src/ifm_queue.sv
src/ifm_front.sv
src/ifm_back.sv
src/interface_face_marker.sv
tb/ifm_marking_checker.sv
tb/interface_face_marker_tb.sv
